>>> sv/hsv2rgb_pkg.sv
// Shared types and constants for the HSV to RGB converter.
// No dependencies; every module of the converter imports this package.
package hsv2rgb_pkg;

  // Field widths of the pixel channels
  localparam int unsigned HueW  = 9;
  localparam int unsigned SvW   = 11;
  localparam int unsigned ChanW = 8;
  localparam int unsigned RemW  = 6;

  // Fixed-point format of saturation and value: SvOne means 1.0
  localparam int unsigned SvBits = 10;
  localparam logic [SvW-1:0] SvOne = 11'd1024;

  // Hue range and sector size in degrees
  localparam logic [HueW-1:0] HueMax = 9'd360;
  localparam int unsigned SectorDeg = 60;

  // Default number of fraction bits of the hue fraction
  localparam int unsigned FracBitsDef = 10;

  // Hue sector, one per 60 degrees
  typedef enum logic [2:0] {
    SecRedYel = 3'd0,
    SecYelGrn = 3'd1,
    SecGrnCyn = 3'd2,
    SecCynBlu = 3'd3,
    SecBluMag = 3'd4,
    SecMagRed = 3'd5
  } sector_e;

  // Input item
  typedef struct packed {
    logic [HueW-1:0] hue;
    logic [SvW-1:0]  saturation;
    logic [SvW-1:0]  brightness;
  } hsv_t;

  // Result item
  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

endpackage

>>> sv/hsv2rgb_sector.sv
// First pipeline stage: clamp the inputs, split hue into sector and fraction.
// Depends on hsv2rgb_pkg.
module hsv2rgb_sector
  import hsv2rgb_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  hsv_t                 pix_i,
  output logic                 valid_o,
  input  logic                 stall_i,
  output sector_e              sector_o,
  output logic [FRAC_BITS-1:0] frac_o,
  output logic [SvW-1:0]       sat_o,
  output logic [SvW-1:0]       bri_o
);

  typedef logic [FRAC_BITS-1:0] frac_lut_t [SectorDeg];

  // Fraction table: floor(rem * 2^FRAC_BITS / 60), built at elaboration
  function automatic frac_lut_t build_lut();
    frac_lut_t lut;
    for (int i = 0; i < SectorDeg; i++) begin
      lut[i] = FRAC_BITS'((longint'(i) << FRAC_BITS) / SectorDeg);
    end
    return lut;
  endfunction

  localparam frac_lut_t FracLut = build_lut();

  logic [HueW-1:0]      hue_c;
  logic [SvW-1:0]       sat_c;
  logic [SvW-1:0]       bri_c;
  sector_e              sector_d;
  logic [RemW-1:0]      rem_d;
  logic                 valid_q;
  sector_e              sector_q;
  logic [FRAC_BITS-1:0] frac_q;
  logic [SvW-1:0]       sat_q;
  logic [SvW-1:0]       bri_q;

  // Saturate out-of-range inputs
  assign hue_c = (pix_i.hue > HueMax) ? HueMax : pix_i.hue;
  assign sat_c = (pix_i.saturation > SvOne) ? SvOne : pix_i.saturation;
  assign bri_c = (pix_i.brightness > SvOne) ? SvOne : pix_i.brightness;

  // Find the sector and the degrees left within it; 360 wraps to sector 0
  always_comb begin
    if (hue_c >= HueMax) begin
      sector_d = SecRedYel;
      rem_d    = '0;
    end else if (hue_c >= HueW'(5 * SectorDeg)) begin
      sector_d = SecMagRed;
      rem_d    = RemW'(hue_c - HueW'(5 * SectorDeg));
    end else if (hue_c >= HueW'(4 * SectorDeg)) begin
      sector_d = SecBluMag;
      rem_d    = RemW'(hue_c - HueW'(4 * SectorDeg));
    end else if (hue_c >= HueW'(3 * SectorDeg)) begin
      sector_d = SecCynBlu;
      rem_d    = RemW'(hue_c - HueW'(3 * SectorDeg));
    end else if (hue_c >= HueW'(2 * SectorDeg)) begin
      sector_d = SecGrnCyn;
      rem_d    = RemW'(hue_c - HueW'(2 * SectorDeg));
    end else if (hue_c >= HueW'(SectorDeg)) begin
      sector_d = SecYelGrn;
      rem_d    = RemW'(hue_c - HueW'(SectorDeg));
    end else begin
      sector_d = SecRedYel;
      rem_d    = RemW'(hue_c);
    end
  end

  // Hold while the next stage is full and stalled
  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      sector_q <= sector_d;
      frac_q   <= FracLut[rem_d];
      sat_q    <= sat_c;
      bri_q    <= bri_c;
    end
  end

  assign valid_o  = valid_q;
  assign sector_o = sector_q;
  assign frac_o   = frac_q;
  assign sat_o    = sat_q;
  assign bri_o    = bri_q;

endmodule

>>> sv/hsv2rgb_terms.sv
// Second and third pipeline stages: form 1-S*f, 1-S*(1-f), V*(1-S),
// then multiply the first two by V. Depends on hsv2rgb_pkg.
module hsv2rgb_terms
  import hsv2rgb_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  output logic                             stall_o,
  input  sector_e                          sector_i,
  input  logic [FRAC_BITS-1:0]             frac_i,
  input  logic [SvW-1:0]                   sat_i,
  input  logic [SvW-1:0]                   bri_i,
  output logic                             valid_o,
  input  logic                             stall_i,
  output sector_e                          sector_o,
  output logic [SvW-1:0]                   bri_o,
  output logic [2*SvBits:0]                vp_o,
  output logic [2*SvBits+FRAC_BITS:0]      vq_o,
  output logic [2*SvBits+FRAC_BITS:0]      vt_o
);

  localparam int unsigned OneW  = SvW + FRAC_BITS;
  localparam int unsigned PW    = 2 * SvBits + 1;
  localparam int unsigned ProdW = 2 * SvBits + 1 + FRAC_BITS;
  localparam logic [OneW-1:0] OneFix = {SvOne, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS:0] FracOne = {1'b1, {FRAC_BITS{1'b0}}};

  // Stage A signals
  logic [FRAC_BITS:0]    gfrac;
  logic [OneW-1:0]       sf;
  logic [OneW:0]         sg;
  logic [2*SvW-1:0]      vp_full;
  logic                  a_valid_q;
  logic                  a_stall;
  sector_e               a_sector_q;
  logic [SvW-1:0]        a_bri_q;
  logic [OneW-1:0]       a_oneq_q;
  logic [OneW-1:0]       a_onet_q;
  logic [PW-1:0]         a_vp_q;

  // Stage B signals
  logic [SvW+OneW-1:0]   vq_full;
  logic [SvW+OneW-1:0]   vt_full;
  logic                  b_valid_q;
  logic                  b_stall;
  sector_e               b_sector_q;
  logic [SvW-1:0]        b_bri_q;
  logic [PW-1:0]         b_vp_q;
  logic [ProdW-1:0]      b_vq_q;
  logic [ProdW-1:0]      b_vt_q;

  // Stage A: saturation products against the fraction and its complement
  assign gfrac   = FracOne - {1'b0, frac_i};
  assign sf      = OneW'(sat_i * frac_i);
  assign sg      = (OneW + 1)'(sat_i * gfrac);
  assign vp_full = bri_i * (SvOne - sat_i);

  assign b_stall = b_valid_q && stall_i;
  assign a_stall = a_valid_q && b_stall;
  assign stall_o = a_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (!a_stall) begin
      a_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!a_stall && valid_i) begin
      a_sector_q <= sector_i;
      a_bri_q    <= bri_i;
      a_oneq_q   <= OneFix - sf;
      a_onet_q   <= OneFix - sg[OneW-1:0];
      a_vp_q     <= vp_full[PW-1:0];
    end
  end

  // Stage B: scale the two terms by value
  assign vq_full = a_bri_q * a_oneq_q;
  assign vt_full = a_bri_q * a_onet_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (!b_stall) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!b_stall && a_valid_q) begin
      b_sector_q <= a_sector_q;
      b_bri_q    <= a_bri_q;
      b_vp_q     <= a_vp_q;
      b_vq_q     <= vq_full[ProdW-1:0];
      b_vt_q     <= vt_full[ProdW-1:0];
    end
  end

  assign valid_o  = b_valid_q;
  assign sector_o = b_sector_q;
  assign bri_o    = b_bri_q;
  assign vp_o     = b_vp_q;
  assign vq_o     = b_vq_q;
  assign vt_o     = b_vt_q;

endmodule

>>> sv/hsv2rgb_mix.sv
// Last pipeline stage: scale each term by 255, truncate, route the channels
// by sector and hold the result in the output register. Depends on hsv2rgb_pkg.
module hsv2rgb_mix
  import hsv2rgb_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        stall_o,
  input  sector_e                     sector_i,
  input  logic [SvW-1:0]              bri_i,
  input  logic [2*SvBits:0]           vp_i,
  input  logic [2*SvBits+FRAC_BITS:0] vq_i,
  input  logic [2*SvBits+FRAC_BITS:0] vt_i,
  output logic                        valid_o,
  input  logic                        stall_i,
  output rgb_t                        rgb_o
);

  localparam int unsigned PW    = 2 * SvBits + 1;
  localparam int unsigned ProdW = 2 * SvBits + 1 + FRAC_BITS;
  localparam int unsigned QSh   = 2 * SvBits + FRAC_BITS;

  logic [SvW+ChanW-1:0]   v255;
  logic [PW+ChanW-1:0]    p255;
  logic [ProdW+ChanW-1:0] q255;
  logic [ProdW+ChanW-1:0] t255;
  logic [ChanW-1:0]       cv;
  logic [ChanW-1:0]       cp;
  logic [ChanW-1:0]       cq;
  logic [ChanW-1:0]       ct;
  rgb_t                   rgb_d;
  logic                   valid_q;
  rgb_t                   rgb_q;

  // Multiply by 255 as x*256 - x, then drop the fraction bits
  assign v255 = {bri_i, {ChanW{1'b0}}} - (SvW + ChanW)'(bri_i);
  assign p255 = {vp_i, {ChanW{1'b0}}} - (PW + ChanW)'(vp_i);
  assign q255 = {vq_i, {ChanW{1'b0}}} - (ProdW + ChanW)'(vq_i);
  assign t255 = {vt_i, {ChanW{1'b0}}} - (ProdW + ChanW)'(vt_i);

  assign cv = v255[SvBits+ChanW-1:SvBits];
  assign cp = p255[2*SvBits+ChanW-1:2*SvBits];
  assign cq = q255[QSh+ChanW-1:QSh];
  assign ct = t255[QSh+ChanW-1:QSh];

  // Route channels by sector
  always_comb begin
    unique case (sector_i)
      SecYelGrn: rgb_d = '{red: cq, green: cv, blue: cp};
      SecGrnCyn: rgb_d = '{red: cp, green: cv, blue: ct};
      SecCynBlu: rgb_d = '{red: cp, green: cq, blue: cv};
      SecBluMag: rgb_d = '{red: ct, green: cp, blue: cv};
      SecMagRed: rgb_d = '{red: cv, green: cp, blue: cq};
      default:   rgb_d = '{red: cv, green: ct, blue: cp};
    endcase
  end

  // Output register: hold while the sink stalls
  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      rgb_q <= rgb_d;
    end
  end

  assign valid_o = valid_q;
  assign rgb_o   = rgb_q;

endmodule

>>> sv/hsv_to_rgb_converter.sv
// HSV to RGB converter, four-stage pipeline. One item in and one item out
// per cycle when the sink does not stall; a result passes through the four
// register stages (sector split, which captures the item at acceptance,
// saturation products, value products, scale-and-route with the output
// register). Hue above 360 and saturation or brightness above 1024 are
// saturated. Stalls hold each stage only while the stage after it is full
// and held, so bubbles are squeezed out and the input keeps being taken
// while a finished result waits at the output, until every stage is full.
// Depends on hsv2rgb_pkg.
module hsv_to_rgb_converter
  import hsv2rgb_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FracBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  hsv_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rgb_t out_data_o
);

  localparam int unsigned PW    = 2 * SvBits + 1;
  localparam int unsigned ProdW = 2 * SvBits + 1 + FRAC_BITS;

  logic                 s1_valid;
  logic                 s1_stall;
  sector_e              s1_sector;
  logic [FRAC_BITS-1:0] s1_frac;
  logic [SvW-1:0]       s1_sat;
  logic [SvW-1:0]       s1_bri;

  logic                 s3_valid;
  logic                 s3_stall;
  sector_e              s3_sector;
  logic [SvW-1:0]       s3_bri;
  logic [PW-1:0]        s3_vp;
  logic [ProdW-1:0]     s3_vq;
  logic [ProdW-1:0]     s3_vt;

  // Split hue into sector and fraction
  hsv2rgb_sector #(
    .FRAC_BITS(FRAC_BITS)
  ) u_sector (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .pix_i   (in_data_i),
    .valid_o (s1_valid),
    .stall_i (s1_stall),
    .sector_o(s1_sector),
    .frac_o  (s1_frac),
    .sat_o   (s1_sat),
    .bri_o   (s1_bri)
  );

  // Form the p, q and t products
  hsv2rgb_terms #(
    .FRAC_BITS(FRAC_BITS)
  ) u_terms (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .stall_o (s1_stall),
    .sector_i(s1_sector),
    .frac_i  (s1_frac),
    .sat_i   (s1_sat),
    .bri_i   (s1_bri),
    .valid_o (s3_valid),
    .stall_i (s3_stall),
    .sector_o(s3_sector),
    .bri_o   (s3_bri),
    .vp_o    (s3_vp),
    .vq_o    (s3_vq),
    .vt_o    (s3_vt)
  );

  // Scale, route and register the channels
  hsv2rgb_mix #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_valid),
    .stall_o (s3_stall),
    .sector_i(s3_sector),
    .bri_i   (s3_bri),
    .vp_i    (s3_vp),
    .vq_i    (s3_vq),
    .vt_i    (s3_vt),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .rgb_o   (out_data_o)
  );

endmodule

>>> sv/hsv2rgb_checker.sv
// Port-level checks for the HSV to RGB converter, bound to the top level.
// Depends on hsv2rgb_pkg and hsv_to_rgb_converter.
module hsv2rgb_checker
  import hsv2rgb_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input hsv_t in_data_i,
  input logic out_valid_o,
  input logic out_stall_i,
  input rgb_t out_data_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // A stalled result stays and holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // Input backpressure only when the output holds a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while the pipeline could move");

  // An accepted item reaches the output when the sink does not stall meanwhile
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("result missing after pipeline latency");

  // Zero brightness gives black, in order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.brightness == '0) ##1 !out_stall_i ##1 !out_stall_i
      ##1 !out_stall_i |=> out_data_o == '0)
    else $error("black input did not give a black result");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);
